FILE: hdl/pm_pkg.sv
// ----------------------------------------------------------------------------
// pm_pkg
// Shared constants, command codes and types of the polynomial multiplier.
// ----------------------------------------------------------------------------
package pm_pkg;

  // Sizing of the coefficient stores and of the arithmetic
  localparam int MAX_DEGREE = 31;
  localparam int COEF_WIDTH = 16;

  // Fixed field widths of the channels
  localparam int COEF_IN_W  = 16;
  localparam int IDX_IN_W   = 5;
  localparam int OUT_IDX_W  = 6;
  localparam int TERM_W     = 37;

  // Derived sizes
  localparam int A_DEPTH = MAX_DEGREE + 1;
  localparam int IDX_W   = $clog2(A_DEPTH);
  localparam int P_DEPTH = 2 * MAX_DEGREE + 1;
  localparam int P_IDX_W = $clog2(P_DEPTH);
  localparam int MUL_W   = 2 * COEF_WIDTH;
  localparam int EXT_W   = MUL_W + TERM_W;

  // Command codes
  localparam logic [1:0] CMD_LOAD_A   = 2'd0;
  localparam logic [1:0] CMD_LOAD_B   = 2'd1;
  localparam logic [1:0] CMD_MULTIPLY = 2'd2;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [TERM_W-1:0]     term_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [P_IDX_W-1:0]           pidx_t;

endpackage

FILE: hdl/pm_cmd_if.sv
// ----------------------------------------------------------------------------
// pm_cmd_if
// Command channel: coefficient loads and multiply requests.
// ----------------------------------------------------------------------------
interface pm_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          cmd;
  logic [pm_pkg::IDX_IN_W-1:0]         coef_index;
  logic signed [pm_pkg::COEF_IN_W-1:0] coef_value;
  logic [pm_pkg::IDX_IN_W-1:0]         degree_a;
  logic [pm_pkg::IDX_IN_W-1:0]         degree_b;

  modport source (
    output valid, cmd, coef_index, coef_value, degree_a, degree_b,
    input  ready
  );
  modport sink (
    input  valid, cmd, coef_index, coef_value, degree_a, degree_b,
    output ready
  );
endinterface

FILE: hdl/pm_term_if.sv
// ----------------------------------------------------------------------------
// pm_term_if
// Result channel: one product coefficient per item.
// ----------------------------------------------------------------------------
interface pm_term_if;
  logic                              valid;
  logic                              ready;
  logic [pm_pkg::OUT_IDX_W-1:0]      term_index;
  logic signed [pm_pkg::TERM_W-1:0]  term_value;
  logic [pm_pkg::OUT_IDX_W-1:0]      product_degree;
  logic                              last;

  modport source (
    output valid, term_index, term_value, product_degree, last,
    input  ready
  );
  modport sink (
    input  valid, term_index, term_value, product_degree, last,
    output ready
  );
endinterface

FILE: hdl/polynomial_multiplier.sv
// ----------------------------------------------------------------------------
// polynomial_multiplier
// Loads two coefficient stores, convolves them into a product store and
// streams the trimmed product out from power 0 upward.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | item
//  items   | in  | cmd, coef_index, coef_value, degree_a, degree_b | load or multiply
//  terms   | out | term_index, term_value, product_degree, last    | product coefficient
//
//  A load writes one coefficient. A multiply accumulates every cross product
//  (one cross product per cycle through the product RAM read-modify-write
//  loop), drains the pipeline, then fetches and emits each term in turn,
//  holding on any stall on terms.ready.
//  Reset (rst, synchronous) clears control only; no clearing pass is run.
//  Items are taken only while the block is idle.
// ----------------------------------------------------------------------------
module polynomial_multiplier (
  input  logic     clk,
  input  logic     rst,
  pm_cmd_if.sink   items,
  pm_term_if.source terms
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DRAIN,
    ST_FETCH,
    ST_EMIT
  } state_t;

  state_t state;

  // Loop counters and degrees
  pm_pkg::idx_t  i_q, j_q, da_q, db_q;
  pm_pkg::pidx_t maxnz;
  pm_pkg::pidx_t emit_idx;

  // Input decode
  logic          in_acc;
  logic          idx_ok;
  pm_pkg::idx_t  ld_addr;
  pm_pkg::idx_t  da_in, db_in;
  pm_pkg::coef_t ld_value;
  logic signed [pm_pkg::COEF_WIDTH+pm_pkg::COEF_IN_W-1:0] ld_ext;
  logic          we_a, we_b;

  // RAM read data
  pm_pkg::coef_t a_rd, b_rd;
  pm_pkg::term_t p_rd;
  pm_pkg::pidx_t p_raddr;

  // Pipeline
  pm_pkg::pidx_t k0;
  logic          first0, final0;
  logic          s1_v, s1_first, s1_final;
  pm_pkg::pidx_t s1_k;
  logic          s2_v, s2_first, s2_final;
  pm_pkg::pidx_t s2_k;
  logic signed [pm_pkg::MUL_W-1:0] mul, mul_q;
  logic signed [pm_pkg::EXT_W-1:0] mul_ext;
  pm_pkg::term_t pfwd, pold_q, sum2;
  logic          w_v;
  pm_pkg::pidx_t w_k;
  pm_pkg::term_t w_val;

  // Output registers
  logic          out_valid;
  pm_pkg::pidx_t out_index;
  pm_pkg::term_t out_value;
  logic          out_last;

  // Input decode: loads, index range check, degree saturation
  assign in_acc   = items.valid && items.ready;
  assign idx_ok   = 32'(items.coef_index) <= 32'(pm_pkg::MAX_DEGREE);
  assign ld_addr  = pm_pkg::IDX_W'(items.coef_index);
  assign ld_ext   = (pm_pkg::COEF_WIDTH + pm_pkg::COEF_IN_W)'(items.coef_value);
  assign ld_value = ld_ext[pm_pkg::COEF_WIDTH-1:0];
  assign we_a     = in_acc && (items.cmd == pm_pkg::CMD_LOAD_A) && idx_ok;
  assign we_b     = in_acc && (items.cmd == pm_pkg::CMD_LOAD_B) && idx_ok;

  assign da_in = (32'(items.degree_a) > 32'(pm_pkg::MAX_DEGREE)) ?
                 pm_pkg::IDX_W'(pm_pkg::MAX_DEGREE) : pm_pkg::IDX_W'(items.degree_a);
  assign db_in = (32'(items.degree_b) > 32'(pm_pkg::MAX_DEGREE)) ?
                 pm_pkg::IDX_W'(pm_pkg::MAX_DEGREE) : pm_pkg::IDX_W'(items.degree_b);

  // Issue stage: term k = i + j; first touch zeroes the old sum,
  // last touch makes the term final for the trim tracking
  assign k0     = pm_pkg::P_IDX_W'(i_q) + pm_pkg::P_IDX_W'(j_q);
  assign first0 = (i_q == '0) || (j_q == db_q);
  assign final0 = (j_q == '0) || (i_q == da_q);

  always_comb begin
    case (state)
      ST_ACC:  p_raddr = k0;
      ST_EMIT: p_raddr = emit_idx + pm_pkg::pidx_t'(1);
      default: p_raddr = emit_idx;
    endcase
  end

  // Coefficient and product stores
  pm_ram #(.WIDTH(pm_pkg::COEF_WIDTH), .DEPTH(pm_pkg::A_DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (ld_addr),
    .wdata (ld_value),
    .raddr (i_q),
    .rdata (a_rd)
  );

  pm_ram #(.WIDTH(pm_pkg::COEF_WIDTH), .DEPTH(pm_pkg::A_DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (ld_addr),
    .wdata (ld_value),
    .raddr (j_q),
    .rdata (b_rd)
  );

  pm_ram #(.WIDTH(pm_pkg::TERM_W), .DEPTH(pm_pkg::P_DEPTH)) u_product (
    .clk   (clk),
    .we    (s2_v),
    .waddr (s2_k),
    .wdata (sum2),
    .raddr (p_raddr),
    .rdata (p_rd)
  );

  // Stage 1: multiply; forward writes the RAM read could not yet see
  assign mul = pm_pkg::MUL_W'(a_rd) * pm_pkg::MUL_W'(b_rd);

  always_comb begin
    if (s2_v && (s2_k == s1_k)) begin
      pfwd = sum2;
    end else if (w_v && (w_k == s1_k)) begin
      pfwd = w_val;
    end else begin
      pfwd = p_rd;
    end
  end

  // Stage 2: accumulate modulo 2^TERM_W
  assign mul_ext = pm_pkg::EXT_W'(mul_q);
  assign sum2    = (s2_first ? pm_pkg::term_t'(0) : pold_q) + mul_ext[pm_pkg::TERM_W-1:0];

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      w_v  <= 1'b0;
    end else begin
      s1_v <= (state == ST_ACC);
      s2_v <= s1_v;
      w_v  <= s2_v;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    s1_k     <= k0;
    s1_first <= first0;
    s1_final <= final0;
    s2_k     <= s1_k;
    s2_first <= s1_first;
    s2_final <= s1_final;
    mul_q    <= mul;
    pold_q   <= pfwd;
    w_k      <= s2_k;
    w_val    <= sum2;
  end

  // Sequencer, trim tracking and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc && (items.cmd == pm_pkg::CMD_MULTIPLY)) begin
            da_q     <= da_in;
            db_q     <= db_in;
            i_q      <= '0;
            j_q      <= '0;
            maxnz    <= '0;
            emit_idx <= '0;
            state    <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (j_q == db_q) begin
            j_q <= '0;
            i_q <= i_q + pm_pkg::idx_t'(1);
          end else begin
            j_q <= j_q + pm_pkg::idx_t'(1);
          end
          if ((i_q == da_q) && (j_q == db_q)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // read of term 0 issues once the last write has landed
          if (!s1_v && !s2_v) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          out_valid <= 1'b1;
          out_index <= emit_idx;
          out_value <= p_rd;
          out_last  <= (emit_idx == maxnz);
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (terms.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx + pm_pkg::pidx_t'(1);
              state    <= ST_FETCH;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      // highest final non-zero term gives the trimmed degree
      if (s2_v && s2_final && (sum2 != '0) && (s2_k > maxnz)) begin
        maxnz <= s2_k;
      end
    end
  end

  // Port drive
  assign items.ready          = (state == ST_IDLE);
  assign terms.valid          = out_valid;
  assign terms.term_index     = pm_pkg::OUT_IDX_W'(out_index);
  assign terms.term_value     = out_value;
  assign terms.product_degree = pm_pkg::OUT_IDX_W'(maxnz);
  assign terms.last           = out_last;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    terms.valid |-> !items.ready)
    else $error("item accepted while a term is pending");

  assert property (@(posedge clk) disable iff (rst)
    s2_v |-> (state == ST_ACC || state == ST_DRAIN))
    else $error("product write outside accumulation");

  assert property (@(posedge clk) disable iff (rst)
    (terms.valid && terms.last) |-> (terms.term_index == terms.product_degree))
    else $error("last term index differs from product degree");

  assert property (@(posedge clk) disable iff (rst)
    (terms.valid && terms.ready && terms.last) |=> items.ready)
    else $error("block not idle after last term");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |=> terms.valid)
    else $error("fetched term not presented");
`endif

endmodule

FILE: hdl/pm_ram.sv
// ----------------------------------------------------------------------------
// pm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pm_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read before write: a same-cycle collision returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
